// File: rtl/size_class_block_cache_defines.svh
// Assertion shorthands used by the checker file.
`ifndef SIZE_CLASS_BLOCK_CACHE_DEFINES_SVH
`define SIZE_CLASS_BLOCK_CACHE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SCCB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SCCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sccb_pkg.sv
package sccb_pkg;

    // Size classes and pool geometry
    localparam int MIN_CLASS_LOG2  = 4;
    localparam int MAX_CLASS_LOG2  = 9;
    localparam int POOL_DEPTH_LOG2 = 9;
    localparam int ADDR_W          = 32;
    localparam int SIZE_W          = 32;

    localparam int CLASS_COUNT = MAX_CLASS_LOG2 - MIN_CLASS_LOG2 + 1;
    localparam int CLASS_W     = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int FILL_W      = POOL_DEPTH_LOG2 + 1;
    localparam int STORE_DEPTH = CLASS_COUNT << POOL_DEPTH_LOG2;
    localparam int STORE_AW    = CLASS_W + POOL_DEPTH_LOG2;

    localparam logic [FILL_W-1:0] POOL_DEPTH = FILL_W'(1) << POOL_DEPTH_LOG2;

    // Request commands
    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } req_cmd_t;

    // Result codes
    typedef enum logic [1:0] {
        RES_REUSED    = 2'd0,
        RES_MISS      = 2'd1,
        RES_RECYCLED  = 2'd2,
        RES_HEAP_FREE = 2'd3
    } res_status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EMIT
    } fsm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;
        logic lookup;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;
    } dp_stat_t;

    typedef struct packed {
        logic               cacheable;
        logic [CLASS_W-1:0] idx;
    } class_sel_t;

    // Map a size to its class: smallest power of two that covers it
    function automatic class_sel_t size_to_class(logic [SIZE_W-1:0] size);
        class_sel_t r;
        r.cacheable = 1'b0;
        r.idx       = '0;
        for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
            if ({1'b0, size} <= ((SIZE_W+1)'(1) << (k + MIN_CLASS_LOG2))) begin
                r.cacheable = 1'b1;
                r.idx       = CLASS_W'(k);
            end
        end
        return r;
    endfunction

    // Byte size of a class
    function automatic logic [SIZE_W-1:0] class_bytes(logic [CLASS_W-1:0] idx);
        logic [SIZE_W-1:0] one;
        one = SIZE_W'(1);
        return one << (SIZE_W'(idx) + SIZE_W'(MIN_CLASS_LOG2));
    endfunction

endpackage

// File: rtl/sccb_req_if.sv
interface sccb_req_if
    import sccb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [SIZE_W-1:0] request_size;
    logic [31:0]       block_address;

    modport source (output valid, cmd, request_size, block_address, input ready);
    modport sink   (input valid, cmd, request_size, block_address, output ready);
endinterface

// File: rtl/sccb_rsp_if.sv
interface sccb_rsp_if
    import sccb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [31:0]       result_address;
    logic [SIZE_W-1:0] heap_size;

    modport source (output valid, status, result_address, heap_size, input ready);
    modport sink   (input valid, status, result_address, heap_size, output ready);
endinterface

// File: rtl/size_class_block_cache.sv
// Channel | Dir | Word fields
// req     | in  | cmd, request_size, block_address
// rsp     | out | status, result_address, heap_size
//
// One request at a time: accept, look up, emit; no new word is taken
// until the last one is emitted. The address store read is registered, which
// sets the lookup-to-emit step. A stalled rsp holds the emit step, and
// req stays low until the result is in the output register.
// rst_n clears all class queues to empty; the store itself needs no clearing.
module size_class_block_cache
    import sccb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sccb_req_if.sink      req,
    sccb_rsp_if.source    rsp
);

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    sccb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    sccb_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctrl_cmd),
        .stat       (dp_stat),
        .in_cmd     (req.cmd),
        .in_size    (req.request_size),
        .in_addr    (req.block_address),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp.status),
        .out_addr   (rsp.result_address),
        .out_heap   (rsp.heap_size)
    );

endmodule

// File: rtl/sccb_ctrl.sv
module sccb_ctrl
    import sccb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one request: accept, look up, emit
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.load_req = 1'b0;
        cmd.lookup   = 1'b0;
        cmd.emit     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/sccb_dp.sv
module sccb_dp
    import sccb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_stat_t          stat,
    // request word
    input  logic              in_cmd,
    input  logic [SIZE_W-1:0] in_size,
    input  logic [31:0]       in_addr,
    // result word
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        out_status,
    output logic [31:0]       out_addr,
    output logic [SIZE_W-1:0] out_heap
);

    // Latched request
    logic               req_cmd_reg;
    logic [SIZE_W-1:0]  req_size_reg;
    logic [ADDR_W-1:0]  req_addr_reg;
    logic [CLASS_W-1:0] class_reg;
    logic               cacheable_reg;
    class_sel_t         sel;

    // Per-class queue pointers
    logic [POOL_DEPTH_LOG2-1:0] rd_pos_reg [CLASS_COUNT];
    logic [POOL_DEPTH_LOG2-1:0] wr_pos_reg [CLASS_COUNT];
    logic [FILL_W-1:0]          fill_reg   [CLASS_COUNT];

    // Address store
    logic [ADDR_W-1:0]   store_mem [STORE_DEPTH];
    logic [ADDR_W-1:0]   rdata_reg;
    logic [STORE_AW-1:0] mem_addr;
    logic                mem_we;
    logic                mem_re;

    // Lookup decision
    logic [FILL_W-1:0] cur_fill;
    logic              hit;
    logic              space;
    res_status_t       res_status_next;
    res_status_t       res_status_reg;
    logic [ADDR_W-1:0] res_addr_next;
    logic [ADDR_W-1:0] res_addr_reg;
    logic [SIZE_W-1:0] res_heap_next;
    logic [SIZE_W-1:0] res_heap_reg;

    // Output register
    logic              out_valid_reg;
    logic [1:0]        out_status_reg;
    logic [31:0]       out_addr_reg;
    logic [SIZE_W-1:0] out_heap_reg;

    assign sel = size_to_class(in_size);

    // Capture the request and its class
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_cmd_reg   <= in_cmd;
            req_size_reg  <= in_size;
            req_addr_reg  <= ADDR_W'(in_addr);
            class_reg     <= sel.idx;
            cacheable_reg <= sel.cacheable;
        end
    end

    // Decide hit, push or fall back to the heap
    always_comb
    begin
        cur_fill        = fill_reg[class_reg];
        hit             = cacheable_reg && (cur_fill != '0);
        space           = cacheable_reg && (cur_fill != POOL_DEPTH);
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = {class_reg, rd_pos_reg[class_reg]};
        res_status_next = RES_MISS;
        res_addr_next   = '0;
        res_heap_next   = '0;
        if (req_cmd_reg == CMD_ALLOC)
        begin
            if (hit)
            begin
                mem_re          = cmd.lookup;
                res_status_next = RES_REUSED;
            end
            else
            begin
                res_status_next = RES_MISS;
                res_heap_next   = cacheable_reg ? class_bytes(class_reg) : req_size_reg;
            end
        end
        else
        begin
            mem_addr = {class_reg, wr_pos_reg[class_reg]};
            if (space)
            begin
                mem_we          = cmd.lookup;
                res_status_next = RES_RECYCLED;
            end
            else
            begin
                res_status_next = RES_HEAP_FREE;
                res_addr_next   = req_addr_reg;
            end
        end
    end

    // Advance the queue pointers of the selected class
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                rd_pos_reg[i] <= '0;
                wr_pos_reg[i] <= '0;
                fill_reg[i]   <= '0;
            end
        end
        else if (mem_re)
        begin
            rd_pos_reg[class_reg] <= rd_pos_reg[class_reg] + 1'b1;
            fill_reg[class_reg]   <= cur_fill - 1'b1;
        end
        else if (mem_we)
        begin
            wr_pos_reg[class_reg] <= wr_pos_reg[class_reg] + 1'b1;
            fill_reg[class_reg]   <= cur_fill + 1'b1;
        end
    end

    // Store access, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= req_addr_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_addr];
        end
    end

    // Hold the decision until the result register takes it
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            res_status_reg <= res_status_next;
            res_addr_reg   <= res_addr_next;
            res_heap_reg   <= res_heap_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_heap_reg   <= res_heap_reg;
            if (res_status_reg == RES_REUSED)
            begin
                out_addr_reg <= 32'(rdata_reg);
            end
            else
            begin
                out_addr_reg <= 32'(res_addr_reg);
            end
        end
    end

    assign stat.slot_free = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_addr       = out_addr_reg;
    assign out_heap       = out_heap_reg;

endmodule

// File: rtl/sccb_checker.sv
`include "size_class_block_cache_defines.svh"

module sccb_checker
    import sccb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [1:0]        rsp_status,
    input logic [31:0]       rsp_result_address,
    input logic [SIZE_W-1:0] rsp_heap_size
);

    // One request in flight: ready drops right after an accept
    `SCCB_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "req accepted while busy")

    // Stalled result holds
    `SCCB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_address), "rsp dropped or changed under stall")

    // Miss carries a heap size and no address
    `SCCB_ASSERT_NOW(a_miss_fields, rsp_valid && (rsp_status == RES_MISS), (rsp_result_address == '0) && (rsp_heap_size != '0), "bad miss word")

    // Recycle carries neither address nor size
    `SCCB_ASSERT_NOW(a_recycle_fields, rsp_valid && (rsp_status == RES_RECYCLED), (rsp_result_address == '0) && (rsp_heap_size == '0), "bad recycle word")

endmodule

bind size_class_block_cache sccb_checker u_sccb_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_result_address (rsp.result_address),
    .rsp_heap_size      (rsp.heap_size)
);

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import sccb_pkg::*;

    localparam int POOL_CAP = 1 << POOL_DEPTH_LOG2;

    typedef struct packed {
        req_cmd_t    cmd;
        logic [31:0] size;
        logic [31:0] addr;
    } cache_req_t;

    typedef struct packed {
        res_status_t status;
        logic [31:0] address;
        logic [31:0] heap;
    } cache_res_t;

    // One directed word; the result is typed in only where known is set
    typedef struct packed {
        req_cmd_t    cmd;
        logic [31:0] size;
        logic [31:0] addr;
        logic        known;
        res_status_t status;
        logic [31:0] address;
        logic [31:0] heap;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sccb_req_if req_ch ();
    sccb_rsp_if rsp_ch ();

    size_class_block_cache i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the per-class free lists, oldest address at the front
    logic [31:0] free_pool [CLASS_COUNT][$];
    cache_res_t  due_results [$];
    stim_row_t   directed_rows [0:22];

    int fail_count    = 0;
    int sent_count    = 0;
    int results_seen  = 0;
    int send_gap_max  = 0;
    int recv_gap_max  = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Class index of a size, -1 when no class covers it
    function automatic int class_of(logic [31:0] size, output logic [31:0] rounded);
        int idx;
        idx     = -1;
        rounded = '0;
        for (int k = MIN_CLASS_LOG2; k <= MAX_CLASS_LOG2; k++)
        begin
            if (idx < 0 && {1'b0, size} <= (33'd1 << k))
            begin
                idx     = k - MIN_CLASS_LOG2;
                rounded = 32'd1 << k;
            end
        end
        return idx;
    endfunction

    // Work out the answer to one word and advance the free lists
    function automatic cache_res_t predict_cache(cache_req_t w);
        cache_res_t  res;
        logic [31:0] rounded;
        int          c;
        res.status  = RES_MISS;
        res.address = '0;
        res.heap    = '0;
        c = class_of(w.size, rounded);
        if (w.cmd == CMD_ALLOC)
        begin
            if (c >= 0 && free_pool[c].size() > 0)
            begin
                res.status  = RES_REUSED;
                res.address = free_pool[c].pop_front();
            end
            else
            begin
                res.status = RES_MISS;
                res.heap   = (c >= 0) ? rounded : w.size;
            end
        end
        else
        begin
            if (c >= 0 && free_pool[c].size() < POOL_CAP)
            begin
                free_pool[c].push_back(w.addr);
                res.status = RES_RECYCLED;
            end
            else
            begin
                res.status  = RES_HEAP_FREE;
                res.address = w.addr;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d, %s: got %h, expected %h",
                 results_seen, what, got, want);
        fail_count++;
    endtask

    // Offer one word after a random gap; record its answer on acceptance
    task automatic offer_request(cache_req_t w, logic known, cache_res_t want);
        int         gap;
        cache_res_t res;
        if (sent_count % 50 == 0)
            send_gap_max = $urandom_range(5, 0);
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= w.cmd;
        req_ch.request_size  <= w.size;
        req_ch.block_address <= w.addr;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        res = predict_cache(w);
        due_results.push_back(known ? want : res);
        sent_count++;
        @(negedge clk);
    endtask

    // Random size that lands in class k
    function automatic logic [31:0] size_in_class(int k);
        int lg;
        logic [31:0] lo;
        logic [31:0] hi;
        lg = MIN_CLASS_LOG2 + k;
        lo = (k == 0) ? 32'd0 : (32'd1 << (lg - 1)) + 32'd1;
        hi = 32'd1 << lg;
        return $urandom_range(hi, lo);
    endfunction

    function automatic cache_req_t random_request();
        cache_req_t w;
        int         pick;
        w.cmd  = ($urandom_range(1, 0) == 1) ? CMD_RELEASE : CMD_ALLOC;
        w.addr = $urandom();
        pick   = $urandom_range(9, 0);
        if (pick <= 6)
            w.size = size_in_class($urandom_range(CLASS_COUNT - 1, 0));
        else if (pick == 7)
            w.size = ($urandom_range(1, 0) == 1) ? 32'd0 :
                     32'd1 << (MIN_CLASS_LOG2 + $urandom_range(CLASS_COUNT - 1, 0));
        else
        begin
            case ($urandom_range(4, 0))
                0: w.size = (32'd1 << MAX_CLASS_LOG2) + 32'd1;
                1: w.size = $urandom_range(65535, (1 << MAX_CLASS_LOG2) + 1);
                2: w.size = {1'b1, 31'($urandom())};
                3: w.size = 32'hFFFF_FFFF;
                default: w.size = $urandom();
            endcase
        end
        return w;
    endfunction

    // Compare each delivered word with the oldest answer due
    always @(posedge clk)
    begin : check_results
        cache_res_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (due_results.size() == 0)
                report_mismatch("result with nothing due", rsp_ch.result_address, '0);
            else
            begin
                want = due_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                if (rsp_ch.result_address !== want.address)
                    report_mismatch("result_address", rsp_ch.result_address, want.address);
                if (rsp_ch.heap_size !== want.heap)
                    report_mismatch("heap_size", rsp_ch.heap_size, want.heap);
            end
            results_seen++;
        end
    end

    // Result side: random stalls, plus two long holds to back up the request side
    initial
    begin : drain_results
        int gap;
        int hold_cycles;
        bit first_hold_done;
        bit second_hold_done;
        first_hold_done  = 1'b0;
        second_hold_done = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (results_seen % 50 == 0)
                recv_gap_max = $urandom_range(5, 0);
            gap = $urandom_range(recv_gap_max, 0);
            if (!first_hold_done && results_seen >= 300)
            begin
                first_hold_done = 1'b1;
                gap = 400;
            end
            else if (!second_hold_done && results_seen >= 1400)
            begin
                second_hold_done = 1'b1;
                gap = 250;
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < gap)
                begin
                    @(negedge clk);
                    hold_cycles++;
                end
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    initial
    begin : run_stimulus
        cache_req_t w;
        cache_res_t want;
        int         fill_class;

        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_ALLOC;
        req_ch.request_size  = '0;
        req_ch.block_address = '0;

        // Start from empty lists: allocate misses, release recycles or frees to the heap, then reuse in order
        directed_rows = '{
            '{CMD_ALLOC,   32'd0,        32'h0,         1'b1, RES_MISS,      32'h0,  32'd16},
            '{CMD_ALLOC,   32'd16,       32'h0,         1'b1, RES_MISS,      32'h0,  32'd16},
            '{CMD_ALLOC,   32'd17,       32'h0,         1'b1, RES_MISS,      32'h0,  32'd32},
            '{CMD_ALLOC,   32'd512,      32'h0,         1'b1, RES_MISS,      32'h0,  32'd512},
            '{CMD_ALLOC,   32'd513,      32'h0,         1'b1, RES_MISS,      32'h0,  32'd513},
            '{CMD_ALLOC,   32'h8000_0001, 32'h0,        1'b1, RES_MISS,      32'h0,
              32'h8000_0001},
            '{CMD_ALLOC,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, RES_MISS,     32'h0,
              32'hFFFF_FFFF},
            '{CMD_RELEASE, 32'd0,        32'hDEAD_0000, 1'b1, RES_RECYCLED,  32'h0,  32'h0},
            '{CMD_RELEASE, 32'd16,       32'hFFFF_FFFF, 1'b1, RES_RECYCLED,  32'h0,  32'h0},
            '{CMD_RELEASE, 32'd300,      32'h1234_5678, 1'b1, RES_RECYCLED,  32'h0,  32'h0},
            '{CMD_RELEASE, 32'd512,      32'h0,         1'b1, RES_RECYCLED,  32'h0,  32'h0},
            '{CMD_RELEASE, 32'd513,      32'hCAFE_F00D, 1'b1, RES_HEAP_FREE,
              32'hCAFE_F00D, 32'h0},
            '{CMD_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, RES_HEAP_FREE,
              32'hFFFF_FFFF, 32'h0},
            '{CMD_RELEASE, 32'h8000_0000, 32'hA5A5_A5A5, 1'b1, RES_HEAP_FREE,
              32'hA5A5_A5A5, 32'h0},
            '{CMD_ALLOC,   32'd1,        32'h0,         1'b1, RES_REUSED,
              32'hDEAD_0000, 32'h0},
            '{CMD_ALLOC,   32'd16,       32'h0,         1'b1, RES_REUSED,
              32'hFFFF_FFFF, 32'h0},
            '{CMD_ALLOC,   32'd16,       32'h0,         1'b1, RES_MISS,      32'h0,  32'd16},
            '{CMD_ALLOC,   32'd257,      32'h0,         1'b1, RES_REUSED,
              32'h1234_5678, 32'h0},
            '{CMD_ALLOC,   32'd512,      32'h0,         1'b1, RES_REUSED,    32'h0,  32'h0},
            '{CMD_RELEASE, 32'd64,       32'h0BAD_BEEF, 1'b0, RES_REUSED,    32'h0,  32'h0},
            '{CMD_RELEASE, 32'd33,       32'h7000_0040, 1'b0, RES_REUSED,    32'h0,  32'h0},
            '{CMD_ALLOC,   32'd64,       32'h0,         1'b0, RES_REUSED,    32'h0,  32'h0},
            '{CMD_ALLOC,   32'd2,        32'h5555_AAAA, 1'b0, RES_REUSED,    32'h0,  32'h0}
        };

        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            w.cmd         = directed_rows[i].cmd;
            w.size        = directed_rows[i].size;
            w.addr        = directed_rows[i].addr;
            want.status   = directed_rows[i].status;
            want.address  = directed_rows[i].address;
            want.heap     = directed_rows[i].heap;
            offer_request(w, directed_rows[i].known, want);
        end

        // Overfill one class so its list wraps and then refuses addresses
        want = '0;
        fill_class = $urandom_range(CLASS_COUNT - 1, 0);
        repeat (POOL_CAP + 28)
        begin
            w.cmd  = CMD_RELEASE;
            w.size = size_in_class(fill_class);
            w.addr = $urandom();
            offer_request(w, 1'b0, want);
        end

        // Mixed traffic over all classes and uncacheable sizes
        repeat (1290)
        begin
            w = random_request();
            offer_request(w, 1'b0, want);
        end

        // Drop valid and drain the remaining answers
        req_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Bound the run far beyond the slowest legal one
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
